// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, prop, msg)
`endif
`endif

// ===== src/hpr_pkg.sv =====
`default_nettype none
package hpr_pkg;
    localparam int unsigned PosW = 32;
    localparam int unsigned AngW = 16;
    localparam logic [15:0] StepTimeReset = 16'd3277;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIN,
        ST_MUL,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== src/holonomic_pose_rollout_top.sv =====
// An input transfer starts the sine steps and then the multiply steps; the result is then offered on m_axis.
// s_axis_tready is low while busy, so a new item is taken only after m_axis has accepted the last result.
// One shared 33 x 33 bit signed multiplier forms the products in turn, apart from two constant terms of the sine.
// Reset (rst_n, asynchronous, active low) zeroes both poses and loads step_time with 3277.
`default_nettype none
`include "assert_macros.svh"
module holonomic_pose_rollout_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: init_x, init_y, init_heading, vel_forward, vel_lateral, turn_rate
    input  wire logic [135:0] s_axis_tdata,
    // tuser: first
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: global_x, global_y, global_heading, local_x, local_y, local_heading
    output logic [159:0]      m_axis_tdata
);
    hpr_pkg::state_t state_reg, state_next;
    logic [4:0]  step_reg;
    logic [15:0] step_time_reg;
    logic signed [31:0] gx_reg, gy_reg, lx_reg, ly_reg;
    logic [15:0] gh_reg, lh_reg;
    logic signed [15:0] vf_reg, vl_reg;
    logic signed [23:0] rate_reg;
    logic [15:0] dh_reg;
    logic signed [16:0] sg_reg, cg_reg, sl_reg, cl_reg;
    logic [15:0] u_reg, u2_reg, u3_reg;
    logic signed [22:0] poly_reg;
    logic signed [33:0] tx_reg, ty_reg;
    logic signed [63:0] prod_reg;
    logic [159:0] out_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // Sine sub-sequence angle selection for step numbers.
    logic [15:0] ang;
    logic [1:0]  quad;
    logic [15:0] u0;
    always_comb
    begin
        case (step_reg[4:2])
            3'd0: ang = gh_reg;
            3'd1: ang = gh_reg + 16'h4000;
            3'd2: ang = lh_reg;
            default: ang = lh_reg + 16'h4000;
        endcase
        quad = ang[15:14];
        u0 = {1'b0, ang[13:0], 1'b0};
        if (quad[0])
        begin
            u0 = 16'h8000 - u0;
        end
    end

    function automatic logic signed [33:0] rnd23(input logic signed [63:0] v);
        logic signed [63:0] t;
        begin
            t = v + 64'sd4194304;
            rnd23 = 34'(t >>> 23);
        end
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [33:0] d);
        logic signed [34:0] s;
        begin
            s = 35'(p) + 35'(d);
            if (s > 35'sh7FFFFFFF)
                sat_add = 32'sh7FFFFFFF;
            else if (s < -35'sh80000000)
                sat_add = -32'sh80000000;
            else
                sat_add = s[31:0];
        end
    endfunction

    // Steps 0 to 15 evaluate sine and cosine (four angles, four steps each), step 16 forms the
    // heading increment, steps 17 to 28 the four position updates and step 29 loads the result.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (step_reg < 5'd16)
        begin
            case (step_reg[1:0])
                2'd0: begin mul_a = 33'(u0); mul_b = 33'(u0); end
                2'd1: begin mul_a = 33'(u2_reg); mul_b = 33'(u_reg); end
                2'd2: begin mul_a = 33'(u3_reg); mul_b = 33'(u2_reg); end
                default: begin mul_a = 33'(u_reg); mul_b = 33'sd51472; end
            endcase
        end
        else
        begin
            case (step_reg)
                5'd16: begin mul_a = 33'(rate_reg); mul_b = 33'(step_time_reg); end
                5'd17: begin mul_a = 33'(vf_reg); mul_b = 33'(cg_reg); end
                5'd18: begin mul_a = 33'(vl_reg); mul_b = 33'(sg_reg); end
                5'd19: begin mul_a = 33'(tx_reg); mul_b = 33'(step_time_reg); end
                5'd20: begin mul_a = 33'(vf_reg); mul_b = 33'(sg_reg); end
                5'd21: begin mul_a = 33'(vl_reg); mul_b = 33'(cg_reg); end
                5'd22: begin mul_a = 33'(ty_reg); mul_b = 33'(step_time_reg); end
                5'd23: begin mul_a = 33'(vf_reg); mul_b = 33'(cl_reg); end
                5'd24: begin mul_a = 33'(vl_reg); mul_b = 33'(sl_reg); end
                5'd25: begin mul_a = 33'(tx_reg); mul_b = 33'(step_time_reg); end
                5'd26: begin mul_a = 33'(vf_reg); mul_b = 33'(sl_reg); end
                5'd27: begin mul_a = 33'(vl_reg); mul_b = 33'(cl_reg); end
                5'd28: begin mul_a = 33'(ty_reg); mul_b = 33'(step_time_reg); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_axis_tready = (state_reg == hpr_pkg::ST_IDLE);
        m_axis_tvalid = (state_reg == hpr_pkg::ST_OUT);
        case (state_reg)
            hpr_pkg::ST_IDLE: if (s_axis_tvalid) state_next = hpr_pkg::ST_SIN;
            hpr_pkg::ST_SIN: if (step_reg == 5'd15) state_next = hpr_pkg::ST_MUL;
            hpr_pkg::ST_MUL: if (step_reg == 5'd29) state_next = hpr_pkg::ST_OUT;
            hpr_pkg::ST_OUT: if (m_axis_tready) state_next = hpr_pkg::ST_IDLE;
            default: state_next = hpr_pkg::ST_IDLE;
        endcase
    end
    assign m_axis_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hpr_pkg::ST_IDLE;
            step_reg <= '0;
            step_time_reg <= hpr_pkg::StepTimeReset;
            gx_reg <= '0; gy_reg <= '0; gh_reg <= '0;
            lx_reg <= '0; ly_reg <= '0; lh_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                step_time_reg <= cfg_wdata;
            if (state_reg == hpr_pkg::ST_IDLE)
            begin
                step_reg <= '0;
                if (s_axis_tvalid && s_axis_tuser)
                begin
                    gx_reg <= s_axis_tdata[31:0];
                    gy_reg <= s_axis_tdata[63:32];
                    gh_reg <= s_axis_tdata[79:64];
                    lx_reg <= '0; ly_reg <= '0; lh_reg <= '0;
                end
            end
            else if (state_reg != hpr_pkg::ST_OUT)
            begin
                step_reg <= step_reg + 5'd1;
                case (step_reg)
                    5'd19: gx_reg <= sat_add(gx_reg, rnd23(mul_p[63:0]));
                    5'd22: gy_reg <= sat_add(gy_reg, rnd23(mul_p[63:0]));
                    5'd25: lx_reg <= sat_add(lx_reg, rnd23(mul_p[63:0]));
                    5'd28:
                    begin
                        ly_reg <= sat_add(ly_reg, rnd23(mul_p[63:0]));
                        gh_reg <= gh_reg + dh_reg;
                        lh_reg <= lh_reg + dh_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    logic [15:0] s_mag;
    logic signed [16:0] s_val;
    logic signed [40:0] acc;
    always_comb
    begin
        // Final polynomial: combine terms held in the product.
        acc = 41'(mul_p[40:0]) - 41'(21024 * 41'(u3_reg)) + 41'(2320 * 41'(poly_reg));
        if (acc < 0)
            acc = '0;
        s_mag = acc[30:15];
        s_val = quad[1] ? -17'(s_mag) : 17'(s_mag);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == hpr_pkg::ST_IDLE)
        begin
            vf_reg <= s_axis_tdata[95:80];
            vl_reg <= s_axis_tdata[111:96];
            rate_reg <= s_axis_tdata[135:112];
            poly_reg <= '0;
        end
        else if (step_reg < 5'd16)
        begin
            case (step_reg[1:0])
                2'd0: begin u_reg <= u0; u2_reg <= 16'(mul_p >>> 15); end
                2'd1: u3_reg <= 16'(mul_p >>> 15);
                2'd2: poly_reg <= 23'(mul_p >>> 15);
                default:
                begin
                    case (step_reg[3:2])
                        2'd0: sg_reg <= s_val;
                        2'd1: cg_reg <= s_val;
                        2'd2: sl_reg <= s_val;
                        default: cl_reg <= s_val;
                    endcase
                end
            endcase
        end
        else
        begin
            case (step_reg)
                5'd16: dh_reg <= 16'((mul_p + 66'sd32768) >>> 16);
                5'd17, 5'd20, 5'd23, 5'd26: tx_reg <= 34'(mul_p);
                5'd18, 5'd24: tx_reg <= tx_reg - 34'(mul_p);
                5'd21, 5'd27: ty_reg <= tx_reg + 34'(mul_p);
                default: ;
            endcase
            if (step_reg == 5'd29)
                out_reg <= {lh_reg, ly_reg, lx_reg, gh_reg, gy_reg, gx_reg};
        end
    end

    `ASSERT_NEVER(a_no_both, s_axis_tready && m_axis_tvalid, "ready while result pending")
    `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "not held")
    `ASSERT_CLK(a_step_rng, step_reg <= 5'd30, "step counter out of range")
endmodule
`default_nettype wire
